// ===== hdl/scm_pkg.sv =====
// Package: types, constants and arithmetic helpers of the scaled control sum mixer.
`timescale 1ns / 1ps

package scm_pkg;

	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FRAC_BITS  = 12;
	localparam int VAL_W      = 16;
	localparam int SUM_W      = 22;
	localparam int PROD_W     = SUM_W + VAL_W;
	localparam int REG_COUNT  = 5;
	localparam int ADDR_W     = $clog2(4 * REG_COUNT);
	localparam int DATA_W     = 32;
	localparam int CHECK_LIM_I = (1001 << FRAC_BITS) / 1000;
	localparam logic signed [VAL_W:0] CHECK_LIM = (VAL_W + 1)'(CHECK_LIM_I);

	typedef enum logic [2:0] {
		REG_OUT_NEG_GAIN = 3'd0,
		REG_OUT_POS_GAIN = 3'd1,
		REG_OUT_BIAS     = 3'd2,
		REG_OUT_LOWER    = 3'd3,
		REG_OUT_UPPER    = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BIAS_HIGH  = 3'd1,
		ST_BIAS_LOW   = 3'd2,
		ST_LOWER_ABOVE = 3'd3,
		ST_LOWER_LOW  = 3'd4,
		ST_UPPER_HIGH = 3'd5
	} status_t;

	typedef enum logic {
		CMD_SAMPLE = 1'b0,
		CMD_LOAD   = 1'b1
	} command_t;

	typedef enum logic {
		KIND_MIX    = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		logic                    command;
		logic [4:0]              slot;
		logic signed [VAL_W-1:0] control_value;
		logic signed [VAL_W-1:0] neg_gain;
		logic signed [VAL_W-1:0] pos_gain;
		logic signed [VAL_W-1:0] bias;
		logic signed [VAL_W-1:0] lower;
		logic signed [VAL_W-1:0] upper;
		logic                    last;
	} req_t;

	typedef struct packed {
		logic                    kind;
		logic signed [VAL_W-1:0] mix_out;
		logic [2:0]              status;
	} res_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] neg_gain;
		logic signed [VAL_W-1:0] pos_gain;
		logic signed [VAL_W-1:0] bias;
		logic signed [VAL_W-1:0] lower;
		logic signed [VAL_W-1:0] upper;
	} scaler_t;

	typedef struct packed {
		logic take;
		logic load;
		logic mul_en;
		logic mul_mix;
		logic acc_en;
		logic push_load;
		logic push_mix;
	} dp_cmd_t;

	function automatic status_t check_scaler(
		input logic signed [VAL_W-1:0] b,
		input logic signed [VAL_W-1:0] lo,
		input logic signed [VAL_W-1:0] hi
	);
		logic signed [VAL_W:0] be;
		logic signed [VAL_W:0] le;
		logic signed [VAL_W:0] he;
		status_t st;
		be = (VAL_W + 1)'(b);
		le = (VAL_W + 1)'(lo);
		he = (VAL_W + 1)'(hi);
		if (be > CHECK_LIM) st = ST_BIAS_HIGH;
		else if (be < -CHECK_LIM) st = ST_BIAS_LOW;
		else if (le > he) st = ST_LOWER_ABOVE;
		else if (le < -CHECK_LIM) st = ST_LOWER_LOW;
		else if (he > CHECK_LIM) st = ST_UPPER_HIGH;
		else st = ST_OK;
		return st;
	endfunction

	// floor shift of the product, add bias, clamp upper first then lower
	function automatic logic signed [VAL_W-1:0] scale_clamp(
		input logic signed [PROD_W-1:0] p,
		input logic signed [VAL_W-1:0]  b,
		input logic signed [VAL_W-1:0]  lo,
		input logic signed [VAL_W-1:0]  hi
	);
		logic signed [PROD_W-1:0] sh;
		logic signed [PROD_W:0]   y;
		logic signed [VAL_W-1:0]  r;
		sh = p >>> FRAC_BITS;
		y  = (PROD_W + 1)'(sh) + (PROD_W + 1)'(b);
		if (y > (PROD_W + 1)'(hi)) r = hi;
		else if (y < (PROD_W + 1)'(lo)) r = lo;
		else r = y[VAL_W-1:0];
		return r;
	endfunction

endpackage

// ===== hdl/scm_regs.sv =====
// Configuration register file of the output scaler, APB-style access.
`timescale 1ns / 1ps

module scm_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [scm_pkg::ADDR_W-1:0]   paddr,
	input  logic [scm_pkg::DATA_W-1:0]   pwdata,
	output logic [scm_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output scm_pkg::scaler_t             cfg
);

	scm_pkg::scaler_t cfg_q;
	scm_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx    = scm_pkg::reg_idx_t'(paddr[scm_pkg::ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neg_gain <= 16'sd4096;
			cfg_q.pos_gain <= 16'sd4096;
			cfg_q.bias     <= 16'sd0;
			cfg_q.lower    <= -16'sd4096;
			cfg_q.upper    <= 16'sd4096;
		end else if (wr_en) begin
			unique case (idx)
				scm_pkg::REG_OUT_NEG_GAIN: cfg_q.neg_gain <= pwdata[scm_pkg::VAL_W-1:0];
				scm_pkg::REG_OUT_POS_GAIN: cfg_q.pos_gain <= pwdata[scm_pkg::VAL_W-1:0];
				scm_pkg::REG_OUT_BIAS:     cfg_q.bias     <= pwdata[scm_pkg::VAL_W-1:0];
				scm_pkg::REG_OUT_LOWER:    cfg_q.lower    <= pwdata[scm_pkg::VAL_W-1:0];
				scm_pkg::REG_OUT_UPPER:    cfg_q.upper    <= pwdata[scm_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			scm_pkg::REG_OUT_NEG_GAIN: prdata = scm_pkg::DATA_W'(cfg_q.neg_gain);
			scm_pkg::REG_OUT_POS_GAIN: prdata = scm_pkg::DATA_W'(cfg_q.pos_gain);
			scm_pkg::REG_OUT_BIAS:     prdata = scm_pkg::DATA_W'(cfg_q.bias);
			scm_pkg::REG_OUT_LOWER:    prdata = scm_pkg::DATA_W'(cfg_q.lower);
			scm_pkg::REG_OUT_UPPER:    prdata = scm_pkg::DATA_W'(cfg_q.upper);
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== hdl/scm_dp.sv =====
// Datapath: slot scaler table, shared multiplier, accumulator and result register.
`timescale 1ns / 1ps

module scm_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  scm_pkg::dp_cmd_t  cmd,
	input  scm_pkg::req_t     req,
	input  scm_pkg::scaler_t  cfg,
	output scm_pkg::res_t     res
);

	scm_pkg::scaler_t mem [scm_pkg::SLOT_COUNT];
	scm_pkg::scaler_t rd_q;
	scm_pkg::scaler_t wr_entry;
	logic [scm_pkg::SLOT_W-1:0] idx;

	logic signed [scm_pkg::VAL_W-1:0]  ctl_q;
	logic [2:0]                        status_q;
	logic signed [scm_pkg::PROD_W-1:0] prod_q;
	logic signed [scm_pkg::SUM_W-1:0]  sum_q;
	scm_pkg::res_t                     res_q;

	logic signed [scm_pkg::SUM_W-1:0] mul_a;
	logic signed [scm_pkg::VAL_W-1:0] mul_b;
	logic signed [scm_pkg::VAL_W-1:0] y;
	logic signed [scm_pkg::VAL_W-1:0] mix;
	logic signed [scm_pkg::SUM_W:0]   sum_ext;
	logic signed [scm_pkg::SUM_W-1:0] sum_sat;

	assign idx = req.slot[scm_pkg::SLOT_W-1:0];

	always_comb begin
		wr_entry.neg_gain = req.neg_gain;
		wr_entry.pos_gain = req.pos_gain;
		wr_entry.bias     = req.bias;
		wr_entry.lower    = req.lower;
		wr_entry.upper    = req.upper;
	end

	always_ff @(posedge clk) begin
		if (cmd.take && cmd.load) begin
			mem[idx] <= wr_entry;
		end
		if (cmd.take) begin
			rd_q     <= mem[idx];
			ctl_q    <= req.control_value;
			status_q <= scm_pkg::check_scaler(req.bias, req.lower, req.upper);
		end
	end

	// one multiplier serves the slot scaler and the output scaler
	always_comb begin
		if (cmd.mul_mix) begin
			mul_a = sum_q;
			mul_b = sum_q[scm_pkg::SUM_W-1] ? cfg.neg_gain : cfg.pos_gain;
		end else begin
			mul_a = scm_pkg::SUM_W'(ctl_q);
			mul_b = ctl_q[scm_pkg::VAL_W-1] ? rd_q.neg_gain : rd_q.pos_gain;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= scm_pkg::PROD_W'(mul_a) * scm_pkg::PROD_W'(mul_b);
		end
	end

	assign y       = scm_pkg::scale_clamp(prod_q, rd_q.bias, rd_q.lower, rd_q.upper);
	assign mix     = scm_pkg::scale_clamp(prod_q, cfg.bias, cfg.lower, cfg.upper);
	assign sum_ext = (scm_pkg::SUM_W + 1)'(sum_q) + (scm_pkg::SUM_W + 1)'(y);

	always_comb begin
		if (sum_ext[scm_pkg::SUM_W] != sum_ext[scm_pkg::SUM_W-1]) begin
			sum_sat = {sum_ext[scm_pkg::SUM_W], {(scm_pkg::SUM_W - 1){~sum_ext[scm_pkg::SUM_W]}}};
		end else begin
			sum_sat = sum_ext[scm_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.push_mix) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_load) begin
			res_q.kind    <= scm_pkg::KIND_STATUS;
			res_q.mix_out <= '0;
			res_q.status  <= status_q;
		end else if (cmd.push_mix) begin
			res_q.kind    <= scm_pkg::KIND_MIX;
			res_q.mix_out <= mix;
			res_q.status  <= scm_pkg::ST_OK;
		end
	end

	assign res = res_q;

endmodule

// ===== hdl/scm_ctrl.sv =====
// Controller: sequences one request through table read, multiply, accumulate and output.
`timescale 1ns / 1ps

module scm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic             cmd_command,
	input  logic             cmd_last,
	output logic             cmd_stall,
	output logic             res_valid,
	input  logic             res_stall,
	output scm_pkg::dp_cmd_t dp_cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_RES,
		S_MUL1,
		S_ACC,
		S_MUL2,
		S_MIX_RES
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   out_valid_q;
	logic   out_free;
	logic   push;

	assign out_free  = !out_valid_q || !res_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = out_valid_q;
	assign push      = dp_cmd.push_load || dp_cmd.push_mix;

	always_comb begin
		dp_cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				dp_cmd.take = cmd_valid;
				dp_cmd.load = cmd_valid && (cmd_command == scm_pkg::CMD_LOAD);
			end
			S_LOAD_RES: dp_cmd.push_load = out_free;
			S_MUL1:     dp_cmd.mul_en = 1'b1;
			S_ACC:      dp_cmd.acc_en = 1'b1;
			S_MUL2: begin
				dp_cmd.mul_en  = 1'b1;
				dp_cmd.mul_mix = 1'b1;
			end
			S_MIX_RES:  dp_cmd.push_mix = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						last_q  <= cmd_last;
						state_q <= (cmd_command == scm_pkg::CMD_LOAD) ? S_LOAD_RES : S_MUL1;
					end
				end
				S_LOAD_RES: if (out_free) state_q <= S_IDLE;
				S_MUL1:     state_q <= S_ACC;
				S_ACC:      state_q <= last_q ? S_MUL2 : S_IDLE;
				S_MUL2:     state_q <= S_MIX_RES;
				S_MIX_RES:  if (out_free) state_q <= S_IDLE;
				default:    state_q <= S_IDLE;
			endcase
		end
	end

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || !res_stall))
		else $error("result pushed over an unaccepted result");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.take |=> cmd_stall)
		else $error("new request taken while one is in progress");

	a_mid_sample_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.take && (cmd_command == scm_pkg::CMD_SAMPLE) && !cmd_last)
		|=> !push ##1 !push ##1 !cmd_stall)
		else $error("non-final sample produced a result or did not finish");

	a_load_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.take && (cmd_command == scm_pkg::CMD_LOAD)) |=> !dp_cmd.mul_en && !dp_cmd.acc_en)
		else $error("load request entered the arithmetic path");

endmodule

// ===== hdl/scaled_control_sum_mixer.sv =====
// Top level of the scaled control sum mixer: register file, controller and datapath.
//
//  channel   dir  handshake             payload
//  cmd       in   cmd_valid/cmd_stall   cmd_data (load or control sample)
//  res       out  res_valid/res_stall   res_data (load status or mixed output)
//  config    in   APB psel/penable      output scaler registers at 4*i
//
// With a registered table read and one shared multiplier, a load passes a status
// state, a sample multiply and accumulate, a final sample also multiply and mix out.
// One request is in flight at a time; cmd_stall is low only when idle.
// A finished result waits in the output register while the next request runs.
// Reset clears control state and the running sum; the slot table is not cleared.
`timescale 1ns / 1ps

module scaled_control_sum_mixer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  scm_pkg::req_t              cmd_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output scm_pkg::res_t              res_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [scm_pkg::ADDR_W-1:0] paddr,
	input  logic [scm_pkg::DATA_W-1:0] pwdata,
	output logic [scm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	scm_pkg::scaler_t cfg;
	scm_pkg::dp_cmd_t dp_cmd;

	scm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_command (cmd_data.command),
		.cmd_last    (cmd_data.last),
		.cmd_stall   (cmd_stall),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.dp_cmd      (dp_cmd)
	);

	scm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dp_cmd),
		.req    (cmd_data),
		.cfg    (cfg),
		.res    (res_data)
	);

endmodule
